// File: sv/ktab_pkg.sv
// ktab_pkg: shared types, widths and codes for the key table block
// no dependencies; used by the channel interfaces and every module of the block

package ktab_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // fixed field widths of the channel words
  localparam int CMD_W    = 2;
  localparam int KEY_W    = 27;
  localparam int IDX_W    = 8;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 9;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_READ   = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_MISSING = 3'd2,
    ST_RANGE   = 3'd3,
    ST_ZERO    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_RDATA,
    S_DONE
  } state_e;

  // request to the key store
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [KEY_W-1:0]  wr_data;
  } mem_req_t;

  // finished result word from the sequencer
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    match_index;
    logic [KEY_W-1:0]    entry_data;
    logic [COUNT_W-1:0]  entry_count;
  } res_t;

endpackage

// File: sv/ktab_cmd_if.sv
// ktab_cmd_if: command channel (valid/ready with cmd, key and index)
// depends on ktab_pkg for field widths

interface ktab_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [ktab_pkg::CMD_W-1:0]    cmd;
  logic [ktab_pkg::KEY_W-1:0]    key;
  logic [ktab_pkg::IDX_W-1:0]    index;

  modport source (output valid, output cmd, output key, output index, input ready);
  modport sink   (input valid, input cmd, input key, input index, output ready);
endinterface

// File: sv/ktab_rsp_if.sv
// ktab_rsp_if: result channel (valid/ready with status, position, data, count)
// depends on ktab_pkg for field widths

interface ktab_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [ktab_pkg::STATUS_W-1:0]   status;
  logic [ktab_pkg::IDX_W-1:0]      match_index;
  logic [ktab_pkg::KEY_W-1:0]      entry_data;
  logic [ktab_pkg::COUNT_W-1:0]    entry_count;

  modport source (output valid, output status, output match_index, output entry_data,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input match_index, input entry_data,
                  input entry_count, output ready);
endinterface

// File: sv/key_table_append_search_delete.sv
// key_table_append_search_delete: top level of the packed key table
// depends on ktab_pkg, ktab_cmd_if, ktab_rsp_if, ktab_mem and ktab_seq
//
// usage
//   cmd_i takes one command word (cmd, key, index); rsp_o returns exactly
//   one result word (status, match_index, entry_data, entry_count) for
//   every command word, in order. both are valid/ready channels
//   one command is in flight at a time: cmd_i.ready is high only while the
//   sequencer is idle
// command flow
//   append, read beyond the count and search of an empty table go straight
//   to the done state; read first fetches the entry from the key store
//   lookup and delete compare the stored keys in order until a match or the
//   last entry; delete on a match then moves every later entry down one
//   place, one entry moved per cycle through the store port
//   the next command word can be taken at the earliest in the same cycle
//   as the result turns valid on rsp_o
// the result sits in an output register; the sequencer waits in its done
// state while a stalled receiver holds an earlier word, so words are never
// lost or overwritten
// reset clears the fill count and the control state only; the key store is
// left as it is, since only filled entries are ever read

module key_table_append_search_delete (
  input  logic         clk_i,
  input  logic         rst_ni,
  ktab_cmd_if.sink     cmd_i,
  ktab_rsp_if.source   rsp_o
);

  ktab_pkg::mem_req_t             mem_req;
  logic [ktab_pkg::KEY_W-1:0]     mem_rd_data;
  ktab_pkg::res_t                 res;
  logic                           res_valid;
  logic                           res_free;

  ktab_pkg::res_t                 rsp_q;
  logic                           rsp_valid_q;

  // output register is free when empty or being drained this cycle
  assign res_free = !rsp_valid_q || rsp_o.ready;

  ktab_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_i.valid),
    .cmd_ready_o   (cmd_i.ready),
    .cmd_i         (cmd_i.cmd),
    .key_i         (cmd_i.key),
    .index_i       (cmd_i.index),
    .res_free_i    (res_free),
    .res_valid_o   (res_valid),
    .res_o         (res),
    .mem_req_o     (mem_req),
    .mem_rd_data_i (mem_rd_data)
  );

  ktab_mem u_mem (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (mem_rd_data)
  );

  // result word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (res_valid) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      rsp_q <= res;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = rsp_q.status;
  assign rsp_o.match_index = rsp_q.match_index;
  assign rsp_o.entry_data  = rsp_q.entry_data;
  assign rsp_o.entry_count = rsp_q.entry_count;

  // a new word never lands on a word the receiver has not yet taken
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && rsp_valid_q |-> rsp_o.ready)
    else $error("result word overwritten while stalled");

  // the fill count never exceeds the table depth
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> 32'(rsp_o.entry_count) <= ktab_pkg::TABLE_DEPTH)
    else $error("entry count beyond table depth");

  // a failed command reports no position and no data
  a_fail_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.status != ktab_pkg::ST_OK)
      |-> (rsp_o.match_index == '0) && (rsp_o.entry_data == '0))
    else $error("failed command returned position or data");

  // no command is taken while a command is still being worked on
  a_one_in_flight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.valid && cmd_i.ready |=> !cmd_i.ready)
    else $error("second command accepted while busy");

endmodule

// File: sv/ktab_mem.sv
// ktab_mem: key store, one write port and one registered read port
// depends on ktab_pkg (mem_req_t, widths)

module ktab_mem (
  input  logic                          clk_i,
  input  ktab_pkg::mem_req_t            req_i,
  output logic [ktab_pkg::KEY_W-1:0]    rd_data_o
);

  logic [ktab_pkg::KEY_W-1:0] mem_q [ktab_pkg::TABLE_DEPTH];
  logic [ktab_pkg::KEY_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: sv/ktab_seq.sv
// ktab_seq: command sequencer with the shared key comparator and shift walker
// depends on ktab_pkg; drives ktab_mem through mem_req_t

module ktab_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  output logic                          cmd_ready_o,
  input  logic [ktab_pkg::CMD_W-1:0]    cmd_i,
  input  logic [ktab_pkg::KEY_W-1:0]    key_i,
  input  logic [ktab_pkg::IDX_W-1:0]    index_i,
  input  logic                          res_free_i,
  output logic                          res_valid_o,
  output ktab_pkg::res_t                res_o,
  output ktab_pkg::mem_req_t            mem_req_o,
  input  logic [ktab_pkg::KEY_W-1:0]    mem_rd_data_i
);

  localparam int ADDR_W = ktab_pkg::ADDR_W;
  localparam int CNT_W  = ktab_pkg::CNT_W;

  ktab_pkg::state_e                 state_q, state_d;
  ktab_pkg::cmd_e                   cmd_q, cmd_d;
  logic [ktab_pkg::KEY_W-1:0]       key_q, key_d;
  logic [CNT_W-1:0]                 count_q, count_d;
  logic [CNT_W-1:0]                 ptr_q, ptr_d;
  logic [ADDR_W-1:0]                chk_q, chk_d;
  logic                             chk_v_q, chk_v_d;
  logic [ADDR_W-1:0]                wa_q, wa_d;
  logic                             wp_q, wp_d;
  logic [ADDR_W-1:0]                pos_q, pos_d;
  ktab_pkg::status_e                status_q, status_d;
  logic [ktab_pkg::KEY_W-1:0]       data_q, data_d;
  logic                             hit;
  logic                             last_chk;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ktab_pkg::S_IDLE;
      count_q <= '0;
      chk_v_q <= 1'b0;
      wp_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      chk_v_q <= chk_v_d;
      wp_q    <= wp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    key_q    <= key_d;
    ptr_q    <= ptr_d;
    chk_q    <= chk_d;
    wa_q     <= wa_d;
    pos_q    <= pos_d;
    status_q <= status_d;
    data_q   <= data_d;
  end

  // the one comparator, shared by lookup and delete
  assign hit      = chk_v_q && (mem_rd_data_i == key_q);
  assign last_chk = chk_v_q && ((CNT_W'(chk_q) + CNT_W'(1)) == count_q);

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    chk_d       = chk_q;
    chk_v_d     = chk_v_q;
    wa_d        = wa_q;
    wp_d        = wp_q;
    pos_d       = pos_q;
    status_d    = status_q;
    data_d      = data_q;
    mem_req_o   = '0;
    cmd_ready_o = 1'b0;
    res_valid_o = 1'b0;

    case (state_q)
      ktab_pkg::S_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          cmd_d    = ktab_pkg::cmd_e'(cmd_i);
          key_d    = key_i;
          status_d = ktab_pkg::ST_OK;
          pos_d    = '0;
          data_d   = '0;
          chk_v_d  = 1'b0;
          ptr_d    = '0;
          state_d  = ktab_pkg::S_DONE;
          case (ktab_pkg::cmd_e'(cmd_i))
            ktab_pkg::CMD_APPEND: begin
              if (key_i == '0) begin
                status_d = ktab_pkg::ST_ZERO;
              end else if (count_q == CNT_W'(ktab_pkg::TABLE_DEPTH)) begin
                status_d = ktab_pkg::ST_FULL;
              end else begin
                mem_req_o.wr_en   = 1'b1;
                mem_req_o.wr_addr = count_q[ADDR_W-1:0];
                mem_req_o.wr_data = key_i;
                pos_d             = count_q[ADDR_W-1:0];
                count_d           = count_q + CNT_W'(1);
              end
            end
            ktab_pkg::CMD_LOOKUP, ktab_pkg::CMD_DELETE: begin
              if (count_q == '0) begin
                status_d = ktab_pkg::ST_MISSING;
              end else begin
                state_d = ktab_pkg::S_SCAN;
              end
            end
            ktab_pkg::CMD_READ: begin
              if (32'(index_i) < 32'(count_q)) begin
                mem_req_o.rd_en   = 1'b1;
                mem_req_o.rd_addr = ADDR_W'(index_i);
                pos_d             = ADDR_W'(index_i);
                state_d           = ktab_pkg::S_RDATA;
              end else begin
                status_d = ktab_pkg::ST_RANGE;
              end
            end
            default: begin
              status_d = ktab_pkg::ST_RANGE;
            end
          endcase
        end
      end

      // one read issued and one compare done per cycle
      ktab_pkg::S_SCAN: begin
        if (hit) begin
          pos_d   = chk_q;
          chk_v_d = 1'b0;
          if (cmd_q == ktab_pkg::CMD_DELETE) begin
            ptr_d   = CNT_W'(chk_q) + CNT_W'(1);
            wp_d    = 1'b0;
            state_d = ktab_pkg::S_SHIFT;
          end else begin
            state_d = ktab_pkg::S_DONE;
          end
        end else if (last_chk) begin
          status_d = ktab_pkg::ST_MISSING;
          chk_v_d  = 1'b0;
          state_d  = ktab_pkg::S_DONE;
        end else begin
          mem_req_o.rd_en   = 1'b1;
          mem_req_o.rd_addr = ptr_q[ADDR_W-1:0];
          chk_d             = ptr_q[ADDR_W-1:0];
          chk_v_d           = 1'b1;
          ptr_d             = ptr_q + CNT_W'(1);
        end
      end

      // move entry ptr to ptr-1; each entry is read in the cycle before its write
      ktab_pkg::S_SHIFT: begin
        if (wp_q) begin
          mem_req_o.wr_en   = 1'b1;
          mem_req_o.wr_addr = wa_q;
          mem_req_o.wr_data = mem_rd_data_i;
        end
        if (ptr_q < count_q) begin
          mem_req_o.rd_en   = 1'b1;
          mem_req_o.rd_addr = ptr_q[ADDR_W-1:0];
          wa_d              = ADDR_W'(ptr_q - CNT_W'(1));
          wp_d              = 1'b1;
          ptr_d             = ptr_q + CNT_W'(1);
        end else begin
          wp_d = 1'b0;
          if (!wp_q) begin
            count_d = count_q - CNT_W'(1);
            state_d = ktab_pkg::S_DONE;
          end
        end
      end

      ktab_pkg::S_RDATA: begin
        data_d  = mem_rd_data_i;
        state_d = ktab_pkg::S_DONE;
      end

      ktab_pkg::S_DONE: begin
        if (res_free_i) begin
          res_valid_o = 1'b1;
          state_d     = ktab_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = ktab_pkg::S_IDLE;
      end
    endcase
  end

  assign res_o.status      = status_q;
  assign res_o.match_index = ktab_pkg::IDX_W'(pos_q);
  assign res_o.entry_data  = data_q;
  assign res_o.entry_count = ktab_pkg::COUNT_W'(count_q);

endmodule
